>>> rtl/core/sprq_pkg.sv
`timescale 1ns / 1ps

package sprq_pkg;

  localparam int TASK_W   = 6;
  localparam int KIND_W   = 2;
  localparam int PRIO_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_RESUME  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_YIELD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUSPEND = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } sprq_in_t;

  typedef struct packed {
    logic [TASK_W-1:0]   running_task;
    logic [TASK_W-1:0]   previous_task;
    logic                switched;
    logic [STATUS_W-1:0] status;
  } sprq_out_t;

endpackage

>>> rtl/core/sprq_link_mem.sv
`timescale 1ns / 1ps

module sprq_link_mem
  import sprq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [TASK_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [TASK_W-1:0]        rdata
);

  logic [TASK_W-1:0] mem [DEPTH];
  logic [TASK_W-1:0] rdata_r;

  // A read of the address written in the same cycle returns the new word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/sprq_core.sv
`timescale 1ns / 1ps

module sprq_core
  import sprq_pkg::*;
#(
  parameter int NUM_LEVELS = 4,
  parameter int NUM_TASKS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_vld,
  input  sprq_in_t  item,
  output sprq_out_t result
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int AW = $clog2(NUM_TASKS);

  logic [NUM_LEVELS-1:0] ne_r, ne_nxt;
  logic [TASK_W-1:0]     head_r [NUM_LEVELS];
  logic [TASK_W-1:0]     head_nxt [NUM_LEVELS];
  logic [TASK_W-1:0]     tail_r [NUM_LEVELS];
  logic [TASK_W-1:0]     tail_nxt [NUM_LEVELS];
  logic [TASK_W-1:0]     sec_r [NUM_LEVELS];
  logic [TASK_W-1:0]     sec_nxt [NUM_LEVELS];
  logic [NUM_TASKS-1:0]  ready_r, ready_nxt;
  logic [TASK_W-1:0]     run_id_r, run_id_nxt;
  logic [LW-1:0]         run_lvl_r, run_lvl_nxt;
  logic                  fill_r, fill_nxt;
  logic [LW-1:0]         fill_lvl_r, fill_lvl_nxt;

  logic              link_we;
  logic [AW-1:0]     link_waddr;
  logic [TASK_W-1:0] link_wdata;
  logic [AW-1:0]     link_raddr;
  logic [TASK_W-1:0] link_rdata;

  sprq_link_mem #(
    .DEPTH(NUM_TASKS)
  ) u_link_mem (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  // The successor of each level's head is kept in a register; after a pop the
  // new successor arrives from the link store in the next cycle and is merged here.
  always_comb begin
    logic              is_resume;
    logic              is_yield;
    logic              is_suspend;
    logic              tid_ok;
    logic              resume_ok;
    logic              do_app;
    logic [LW-1:0]     app_lvl;
    logic [TASK_W-1:0] app_id;
    logic [LW-1:0]     preq_lvl;
    logic              found;
    logic [LW-1:0]     pop_lvl;
    logic              do_pop;
    logic [STATUS_W-1:0] status;

    for (int i = 0; i < NUM_LEVELS; i++) begin
      sec_nxt[i] = (fill_r && (fill_lvl_r == LW'(i))) ? link_rdata : sec_r[i];
    end
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    ne_nxt      = ne_r;
    ready_nxt   = ready_r;
    run_id_nxt  = run_id_r;
    run_lvl_nxt = run_lvl_r;
    status      = ST_OK;

    is_resume  = item_vld && (item.kind == KIND_RESUME);
    is_yield   = item_vld && (item.kind == KIND_YIELD);
    is_suspend = item_vld && (item.kind == KIND_SUSPEND);
    tid_ok     = int'(item.task_id) < NUM_TASKS;
    resume_ok  = is_resume && tid_ok && !ready_r[AW'(item.task_id)];
    preq_lvl   = (int'(item.priority_req) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                         : LW'(item.priority_req);

    do_app  = resume_ok || is_yield;
    app_lvl = is_yield ? run_lvl_r : preq_lvl;
    app_id  = is_yield ? run_id_r : item.task_id;

    link_we    = 1'b0;
    link_waddr = AW'(tail_r[app_lvl]);
    link_wdata = app_id;

    if (resume_ok) begin
      ready_nxt[AW'(item.task_id)] = 1'b1;
    end
    if (is_resume && !resume_ok) begin
      status = ST_REJECT;
    end

    if (do_app) begin
      if (ne_r[app_lvl]) begin
        link_we = 1'b1;
        tail_nxt[app_lvl] = app_id;
        if (head_r[app_lvl] == tail_r[app_lvl]) begin
          sec_nxt[app_lvl] = app_id;
        end
      end else begin
        head_nxt[app_lvl] = app_id;
        tail_nxt[app_lvl] = app_id;
        ne_nxt[app_lvl]   = 1'b1;
      end
    end

    found   = 1'b0;
    pop_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ne_nxt[i]) begin
        found   = 1'b1;
        pop_lvl = LW'(i);
      end
    end

    do_pop       = (is_yield || is_suspend) && found;
    fill_nxt     = 1'b0;
    fill_lvl_nxt = pop_lvl;
    link_raddr   = AW'(sec_nxt[pop_lvl]);

    if (is_suspend && !found) begin
      status = ST_EMPTY;
    end

    if (do_pop) begin
      run_id_nxt  = head_nxt[pop_lvl];
      run_lvl_nxt = pop_lvl;
      if (is_suspend) begin
        ready_nxt[AW'(run_id_r)] = 1'b0;
      end
      if (head_nxt[pop_lvl] == tail_nxt[pop_lvl]) begin
        ne_nxt[pop_lvl] = 1'b0;
      end else begin
        head_nxt[pop_lvl] = sec_nxt[pop_lvl];
        if (sec_nxt[pop_lvl] != tail_nxt[pop_lvl]) begin
          fill_nxt = 1'b1;
        end
      end
    end

    result.running_task  = run_id_nxt;
    result.previous_task = run_id_r;
    result.switched      = run_id_nxt != run_id_r;
    result.status        = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r       <= '0;
      ready_r    <= NUM_TASKS'(1);
      run_id_r   <= '0;
      run_lvl_r  <= LW'(NUM_LEVELS - 1);
      fill_r     <= 1'b0;
      fill_lvl_r <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        sec_r[i]  <= '0;
      end
    end else begin
      ne_r       <= ne_nxt;
      ready_r    <= ready_nxt;
      run_id_r   <= run_id_nxt;
      run_lvl_r  <= run_lvl_nxt;
      fill_r     <= fill_nxt;
      fill_lvl_r <= fill_lvl_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      sec_r      <= sec_nxt;
    end
  end

endmodule

>>> rtl/core/strict_priority_ready_queue_unit.sv
`timescale 1ns / 1ps

// Strict priority ready queue with one FIFO of task ids per level, level 0
// highest. A command word is taken whenever start is high and busy is low;
// busy stays low, so a new word can be issued in every cycle. Each word gives
// exactly one result word; the word is registered in in_r, the core's result
// in out_r, and is shown on out_result for one cycle while out_valid is high;
// the receiver cannot stall it and must take it then. The queue state is
// updated once per word; a popped task's successor is refetched from the link
// store in the following cycle. No clearing pass is needed after reset.
module strict_priority_ready_queue_unit
  import sprq_pkg::*;
#(
  parameter int NUM_LEVELS = 4,
  parameter int NUM_TASKS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sprq_in_t  in_item,
  output logic      out_valid,
  output sprq_out_t out_result
);

  logic      in_vld_r;
  sprq_in_t  in_r;
  logic      out_valid_r;
  sprq_out_t out_r;
  sprq_out_t core_result;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_vld_r    <= start && !busy;
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_item;
    out_r <= core_result;
  end

  sprq_core #(
    .NUM_LEVELS(NUM_LEVELS),
    .NUM_TASKS (NUM_TASKS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_vld(in_vld_r),
    .item    (in_r),
    .result  (core_result)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule
